// ===== sv/plt_pkg.sv =====
// Shared types and constants for the piecewise-linear table lookup block.
// Holds the transfer structs, command, status and sequencer codes, and datapath widths.
// Depends on nothing; plt_div and the top level import it.
package plt_pkg;

    localparam int KEY_W  = 16;
    localparam int VAL_W  = 16;
    localparam int ENT_W  = KEY_W + VAL_W;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 2;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_STORED  = 3'd0,
        STAT_DROPPED = 3'd1,
        STAT_EXACT   = 3'd2,
        STAT_INTERP  = 3'd3,
        STAT_BELOW   = 3'd4,
        STAT_ABOVE   = 3'd5,
        STAT_TOOFEW  = 3'd6,
        STAT_CLEARED = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEG,
        ST_MUL,
        ST_DIVGO,
        ST_DIVWAIT
    } state_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] entry_value;
    } plt_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        status_t                 status;
        logic                    saturated;
    } plt_out_t;

endpackage

// ===== sv/plt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Width and depth are parameters; no package dependency.
module plt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/plt_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on plt_pkg for the product and difference widths.
module plt_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [plt_pkg::PROD_W-1:0]  num,
    input  logic signed [plt_pkg::DIFF_W-1:0]  den,
    output logic                               done,
    output logic signed [plt_pkg::PROD_W-1:0]  quot
);
    import plt_pkg::*;

    localparam int STEP_W = $clog2(PROD_W + 1);
    localparam int REM_W  = DIFF_W - 1;

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W-1:0]    dmag_reg, dmag_next;
    logic                neg_reg, neg_next;

    logic [REM_W:0]      shifted;
    logic [REM_W:0]      diff;
    logic                ge;
    logic [PROD_W-1:0]   num_mag;
    logic [DIFF_W-1:0]   den_mag;

    assign num_mag = num[PROD_W-1] ? (~num + PROD_W'(1)) : num;
    assign den_mag = den[DIFF_W-1] ? (~den + DIFF_W'(1)) : den;
    assign shifted = {rem_reg, acc_reg[PROD_W-1]};
    assign diff    = shifted - {1'b0, dmag_reg};
    assign ge      = (shifted >= {1'b0, dmag_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            acc_next  = num_mag;
            rem_next  = '0;
            dmag_next = den_mag[REM_W-1:0];
            neg_next  = num[PROD_W-1] ^ den[DIFF_W-1];
        end
        else if (run_reg)
        begin
            rem_next  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            acc_next  = {acc_reg[PROD_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(PROD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? signed'(~acc_reg + PROD_W'(1)) : signed'(acc_reg);

endmodule

// ===== sv/piecewise_linear_table_interp.sv =====
// Top level of the piecewise-linear breakpoint table with interpolating lookup.
// Depends on plt_pkg, plt_ram (breakpoint storage) and plt_div (serial divider).
//
//   Channel  | Signals                 | Handshake
//   ---------+-------------------------+----------------------------------------------
//   command  | start, busy, item       | transfer when start is high and busy is low
//   result   | done, result            | one-cycle strobe on done, cannot be held off
//
// Append, clear and unused commands answer on the cycle after the transfer and
// keep busy low, so they may follow each other every cycle. A query scans the
// stored pairs with one RAM read per stored entry, then takes a multiply state
// and, unless the segment has zero width, the bit-serial divider, which sets
// the bulk of the latency. busy stays high for the whole query. Reset clears
// the entry count and control state; the table contents stay undefined until written.
module piecewise_linear_table_interp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  plt_pkg::plt_in_t item,
    output logic             done,
    output plt_pkg::plt_out_t result
);
    import plt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Control state.
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic              pend_first_reg, pend_first_next;
    logic              found_reg, found_next;
    logic              done_reg, done_next;

    // Datapath registers.
    plt_out_t                  result_reg, result_next;
    logic signed [KEY_W-1:0]   q_reg, q_next;
    logic                      below0_reg, below0_next;
    logic signed [VAL_W-1:0]   val0_reg, val0_next;
    logic signed [KEY_W-1:0]   prev_k_reg, prev_k_next, last_k_reg, last_k_next;
    logic signed [VAL_W-1:0]   prev_v_reg, prev_v_next, last_v_reg, last_v_next;
    logic signed [KEY_W-1:0]   seg_k0_reg, seg_k0_next, seg_k1_reg, seg_k1_next;
    logic signed [VAL_W-1:0]   seg_v0_reg, seg_v0_next, seg_v1_reg, seg_v1_next;
    status_t                   stat_reg, stat_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [DIFF_W-1:0]  dk_reg, dk_next;

    // RAM port signals.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    // Divider signals.
    logic                      div_start;
    logic                      div_done;
    logic signed [PROD_W-1:0]  div_quot;

    // Arithmetic helpers.
    logic signed [KEY_W-1:0]   rd_key;
    logic signed [VAL_W-1:0]   rd_val;
    logic signed [DIFF_W-1:0]  dx, dv, dk;
    logic signed [PROD_W-1:0]  prod_w;
    logic signed [SUM_W-1:0]   sum_w;

    plt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    plt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (dk_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Each stored entry holds the key in the upper half and the value in the lower half.
    assign rd_key = signed'(ram_rdata[ENT_W-1:VAL_W]);
    assign rd_val = signed'(ram_rdata[VAL_W-1:0]);

    // Segment differences, one multiplier feeding a product register.
    assign dx     = DIFF_W'(q_reg) - DIFF_W'(seg_k0_reg);
    assign dv     = DIFF_W'(seg_v1_reg) - DIFF_W'(seg_v0_reg);
    assign dk     = DIFF_W'(seg_k1_reg) - DIFF_W'(seg_k0_reg);
    assign prod_w = dx * dv;

    // Lower value plus the truncated quotient, wide enough to never wrap.
    assign sum_w  = SUM_W'(seg_v0_reg) + SUM_W'(div_quot);

    assign div_start = (state_reg == ST_DIVGO);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_first_next = 1'b0;
        found_next      = found_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        q_next          = q_reg;
        below0_next     = below0_reg;
        val0_next       = val0_reg;
        prev_k_next     = prev_k_reg;
        prev_v_next     = prev_v_reg;
        last_k_next     = last_k_reg;
        last_v_next     = last_v_reg;
        seg_k0_next     = seg_k0_reg;
        seg_k1_next     = seg_k1_reg;
        seg_v0_next     = seg_v0_reg;
        seg_v1_next     = seg_v1_reg;
        stat_next       = stat_reg;
        prod_next       = prod_reg;
        dk_next         = dk_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = {item.key, item.entry_value};
        ram_re          = 1'b0;
        ram_raddr       = issue_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Non-query commands answer with a zero value and no clamp.
                    result_next.result_value = '0;
                    result_next.saturated    = 1'b0;
                    case (item.cmd)
                        CMD_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg < CW'(TABLE_DEPTH))
                            begin
                                ram_we             = 1'b1;
                                count_next         = count_reg + CW'(1);
                                result_next.status = STAT_STORED;
                            end
                            else
                            begin
                                result_next.status = STAT_DROPPED;
                            end
                        end
                        CMD_QUERY:
                        begin
                            q_next     = item.key;
                            issue_next = '0;
                            found_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            done_next          = 1'b1;
                            count_next         = '0;
                            result_next.status = STAT_CLEARED;
                        end
                        default:
                        begin
                            done_next          = 1'b1;
                            result_next.status = STAT_DROPPED;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Reads are issued one per cycle and checked when the registered read data arrives.
                if (issue_reg < count_reg)
                begin
                    ram_re          = 1'b1;
                    issue_next      = issue_reg + CW'(1);
                    pend_next       = 1'b1;
                    pend_first_next = (issue_reg == '0);
                end
                if (pend_reg)
                begin
                    if (rd_key == q_reg)
                    begin
                        // The earliest equal key wins outright.
                        result_next.result_value = rd_val;
                        result_next.status       = STAT_EXACT;
                        result_next.saturated    = 1'b0;
                        done_next                = 1'b1;
                        pend_next                = 1'b0;
                        state_next               = ST_IDLE;
                    end
                    else
                    begin
                        if (pend_first_reg)
                        begin
                            below0_next = (q_reg < rd_key);
                            val0_next   = rd_val;
                        end
                        else if (!found_reg && (q_reg < rd_key))
                        begin
                            // First key above the query closes the segment.
                            found_next  = 1'b1;
                            seg_k0_next = last_k_reg;
                            seg_v0_next = last_v_reg;
                            seg_k1_next = rd_key;
                            seg_v1_next = rd_val;
                        end
                        prev_k_next = last_k_reg;
                        prev_v_next = last_v_reg;
                        last_k_next = rd_key;
                        last_v_next = rd_val;
                    end
                end
                else if (issue_reg >= count_reg)
                begin
                    state_next = ST_SEG;
                end
            end

            ST_SEG:
            begin
                if (count_reg < CW'(2))
                begin
                    // Too few pairs to form a segment.
                    result_next.result_value = (count_reg == CW'(1)) ? val0_reg : '0;
                    result_next.status       = STAT_TOOFEW;
                    result_next.saturated    = 1'b0;
                    done_next                = 1'b1;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    if (!found_reg)
                    begin
                        // Past the last key: extend the final segment.
                        seg_k0_next = prev_k_reg;
                        seg_v0_next = prev_v_reg;
                        seg_k1_next = last_k_reg;
                        seg_v1_next = last_v_reg;
                        stat_next   = STAT_ABOVE;
                    end
                    else
                    begin
                        stat_next = below0_reg ? STAT_BELOW : STAT_INTERP;
                    end
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                prod_next = prod_w;
                dk_next   = dk;
                if (dk == '0)
                begin
                    // Zero-width segment returns the lower value.
                    result_next.result_value = seg_v0_reg;
                    result_next.status       = stat_reg;
                    result_next.saturated    = 1'b0;
                    done_next                = 1'b1;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIVGO;
                end
            end

            ST_DIVGO:
            begin
                state_next = ST_DIVWAIT;
            end

            ST_DIVWAIT:
            begin
                if (div_done)
                begin
                    result_next.status = stat_reg;
                    if (sum_w > SUM_W'(32767))
                    begin
                        result_next.result_value = 16'sh7FFF;
                        result_next.saturated    = 1'b1;
                    end
                    else if (sum_w < -SUM_W'(32768))
                    begin
                        result_next.result_value = 16'sh8000;
                        result_next.saturated    = 1'b1;
                    end
                    else
                    begin
                        result_next.result_value = sum_w[VAL_W-1:0];
                        result_next.saturated    = 1'b0;
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            pend_first_reg <= 1'b0;
            found_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
            pend_first_reg <= pend_first_next;
            found_reg      <= found_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        q_reg      <= q_next;
        below0_reg <= below0_next;
        val0_reg   <= val0_next;
        prev_k_reg <= prev_k_next;
        prev_v_reg <= prev_v_next;
        last_k_reg <= last_k_next;
        last_v_reg <= last_v_next;
        seg_k0_reg <= seg_k0_next;
        seg_k1_reg <= seg_k1_next;
        seg_v0_reg <= seg_v0_next;
        seg_v1_reg <= seg_v1_next;
        stat_reg   <= stat_next;
        prod_reg   <= prod_next;
        dk_reg     <= dk_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
